// ===== rtl/core/cmsa_pkg.sv =====
// Shared types and constants for the clip mean / standard deviation accumulator.
// Used by every module under rtl/core except cmsa_ram; depends on nothing else.
package cmsa_pkg;

    localparam int STORE_DEPTH  = 1024;
    localparam int ELEM_AW      = $clog2(STORE_DEPTH);
    localparam int SAMPLE_BITS  = 16;
    localparam int SUM_W        = 32;
    localparam int SQ_W         = 48;
    localparam int CNT_W        = 16;
    localparam int EPC_W        = 11;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [EPC_W-1:0] EPC_RESET = 11'd1024;
    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    // Work classified by the front end
    typedef enum logic [1:0] {
        OP_ADD,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [ELEM_AW-1:0]     idx;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   idx_ok;
        logic                   last;
    } t_job;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_ADD_WB,
        B_RD_WAIT,
        B_MATH,
        B_OUT
    } t_bstate;

    // Arithmetic unit states
    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_DIV_MEAN,
        M_SET_VAR,
        M_DIV_VAR,
        M_ROOT,
        M_FIN
    } t_mstate;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [CNT_W-1:0] cnt;
    } t_math_req;

    typedef struct packed {
        logic                     done;
        logic signed [CNT_W-1:0]  mean;
        logic [CNT_W-1:0]         stdev;
    } t_math_rsp;

endpackage

// ===== rtl/core/cmsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module cmsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cmsa_front.sv =====
// Front end: accepts input transfers, classifies them and queues the work.
// Depends on cmsa_pkg.
module cmsa_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [cmsa_pkg::EPC_W-1:0]          i_epc,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_command,
    input  logic [cmsa_pkg::ELEM_AW-1:0]        i_element_index,
    input  logic signed [cmsa_pkg::SAMPLE_BITS-1:0] i_sample,
    output cmsa_pkg::t_job                      o_job,
    output logic                                o_job_valid,
    input  logic                                i_pop
);

    cmsa_pkg::t_job              r_q [cmsa_pkg::QUEUE_DEPTH];
    logic [cmsa_pkg::QUEUE_AW-1:0] r_wp, r_rp;
    logic [cmsa_pkg::QUEUE_AW:0]   r_cnt;

    cmsa_pkg::t_job job;
    logic           keep;
    logic           idx_ok;
    logic           push;
    logic           pop;

    // Classify the incoming item
    always_comb begin
        idx_ok     = {1'b0, i_element_index} < i_epc;
        job.idx    = i_element_index;
        job.sample = i_sample;
        job.idx_ok = idx_ok;
        job.last   = {1'b0, i_element_index} == (i_epc - 11'd1);
        job.op     = cmsa_pkg::OP_ADD;
        keep       = 1'b0;
        unique case (i_command)
            cmsa_pkg::CMD_ADD: begin
                job.op = cmsa_pkg::OP_ADD;
                keep   = idx_ok;
            end
            cmsa_pkg::CMD_READ: begin
                job.op = cmsa_pkg::OP_READ;
                keep   = 1'b1;
            end
            cmsa_pkg::CMD_RESTART: begin
                job.op = cmsa_pkg::OP_CLEAR;
                keep   = 1'b1;
            end
            default: begin
                keep   = 1'b0;
            end
        endcase
    end

    assign o_ready     = r_cnt != cmsa_pkg::QUEUE_DEPTH[cmsa_pkg::QUEUE_AW:0];
    assign push        = i_valid && o_ready && keep;
    assign o_job_valid = r_cnt != '0;
    assign pop         = i_pop && o_job_valid;
    assign o_job       = r_q[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/cmsa_math.sv =====
// Read arithmetic: shared multiplier, restoring divider and bit-pair square root.
// Depends on cmsa_pkg.
module cmsa_math (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cmsa_pkg::t_math_req i_req,
    output cmsa_pkg::t_math_rsp o_rsp
);

    cmsa_pkg::t_mstate r_state, n_state;
    logic [5:0]  r_iter, n_iter;
    logic        r_neg, n_neg;
    logic [31:0] r_smag, n_smag;
    logic [47:0] r_sq, n_sq;
    logic [15:0] r_cnt, n_cnt;
    logic [63:0] r_prod, n_prod;
    logic [63:0] r_s2, n_s2;
    logic [63:0] r_cs, n_cs;
    logic [31:0] r_csq, n_csq;
    logic [31:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [31:0] r_div, n_div;
    logic [63:0] r_x, n_x;
    logic [63:0] r_res, n_res;
    logic [63:0] r_bit, n_bit;
    logic signed [15:0] r_mean, n_mean;
    logic [15:0] r_stdev, n_stdev;
    logic        r_done, n_done;

    logic [31:0] mul_a, mul_b;
    logic [32:0] trial, tdiff;
    logic        tge;
    logic [63:0] rb;
    logic        take;

    // Divider and root step datapath, and multiplier operand selection
    always_comb begin
        trial = {r_rem, r_quo[63]};
        tge   = trial >= {1'b0, r_div};
        tdiff = trial - {1'b0, r_div};
        rb    = r_res + r_bit;
        take  = r_x >= rb;
        unique case (r_iter[1:0])
            2'd0: begin
                mul_a = r_smag;
                mul_b = r_smag;
            end
            2'd1: begin
                mul_a = {16'd0, r_cnt};
                mul_b = {8'd0, r_sq[23:0]};
            end
            2'd2: begin
                mul_a = {16'd0, r_cnt};
                mul_b = {8'd0, r_sq[47:24]};
            end
            default: begin
                mul_a = {16'd0, r_cnt};
                mul_b = {16'd0, r_cnt};
            end
        endcase
    end

    // Sequence the read arithmetic
    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        n_neg   = r_neg;
        n_smag  = r_smag;
        n_sq    = r_sq;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        n_s2    = r_s2;
        n_cs    = r_cs;
        n_csq   = r_csq;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        n_x     = r_x;
        n_res   = r_res;
        n_bit   = r_bit;
        n_mean  = r_mean;
        n_stdev = r_stdev;
        n_done  = 1'b0;
        unique case (r_state)
            cmsa_pkg::M_IDLE: begin
                if (i_req.start) begin
                    n_neg   = i_req.sum[31];
                    n_smag  = i_req.sum[31] ? (~i_req.sum + 32'd1) : i_req.sum;
                    n_sq    = i_req.sq;
                    n_cnt   = i_req.cnt;
                    n_iter  = '0;
                    n_state = cmsa_pkg::M_MUL;
                end
            end
            cmsa_pkg::M_MUL: begin
                // One product per cycle, consumed the cycle after
                n_prod = mul_a * mul_b;
                n_iter = r_iter + 6'd1;
                unique case (r_iter[2:0])
                    3'd1: n_s2 = r_prod;
                    3'd2: n_cs = {24'd0, r_prod[39:0]};
                    3'd3: n_cs = r_cs + {r_prod[39:0], 24'd0};
                    3'd4: begin
                        n_csq   = r_prod[31:0];
                        n_quo   = {32'd0, r_smag};
                        n_rem   = '0;
                        n_div   = {16'd0, r_cnt};
                        n_iter  = '0;
                        n_state = cmsa_pkg::M_DIV_MEAN;
                    end
                    default: ;
                endcase
            end
            cmsa_pkg::M_DIV_MEAN, cmsa_pkg::M_DIV_VAR: begin
                n_rem  = tge ? tdiff[31:0] : trial[31:0];
                n_quo  = {r_quo[62:0], tge};
                n_iter = r_iter + 6'd1;
                if (r_iter == 6'd63) begin
                    n_state = (r_state == cmsa_pkg::M_DIV_MEAN) ?
                              cmsa_pkg::M_SET_VAR : cmsa_pkg::M_ROOT;
                    n_x     = {r_quo[62:0], tge};
                    n_res   = '0;
                    n_bit   = 64'h4000_0000_0000_0000;
                    n_iter  = '0;
                end
            end
            cmsa_pkg::M_SET_VAR: begin
                // Saturate the mean, then start the variance divide
                if (r_neg) begin
                    n_mean = (r_quo > 64'd32768) ? 16'sh8000
                           : $signed(~r_quo[15:0] + 16'd1);
                end else begin
                    n_mean = (r_quo > 64'd32767) ? 16'sh7FFF : $signed(r_quo[15:0]);
                end
                n_quo   = (r_cs > r_s2) ? (r_cs - r_s2) : 64'd0;
                n_rem   = '0;
                n_div   = r_csq;
                n_iter  = '0;
                n_state = cmsa_pkg::M_DIV_VAR;
            end
            cmsa_pkg::M_ROOT: begin
                n_x    = take ? (r_x - rb) : r_x;
                n_res  = take ? ((r_res >> 1) + r_bit) : (r_res >> 1);
                n_bit  = r_bit >> 2;
                n_iter = r_iter + 6'd1;
                if (r_iter == 6'd31) begin
                    n_state = cmsa_pkg::M_FIN;
                end
            end
            cmsa_pkg::M_FIN: begin
                n_stdev = (r_res > 64'd65535) ? 16'hFFFF : r_res[15:0];
                n_done  = 1'b1;
                n_state = cmsa_pkg::M_IDLE;
            end
            default: n_state = cmsa_pkg::M_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmsa_pkg::M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_iter  <= n_iter;
        r_neg   <= n_neg;
        r_smag  <= n_smag;
        r_sq    <= n_sq;
        r_cnt   <= n_cnt;
        r_prod  <= n_prod;
        r_s2    <= n_s2;
        r_cs    <= n_cs;
        r_csq   <= n_csq;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_div   <= n_div;
        r_x     <= n_x;
        r_res   <= n_res;
        r_bit   <= n_bit;
        r_mean  <= n_mean;
        r_stdev <= n_stdev;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.mean  = r_mean;
    assign o_rsp.stdev = r_stdev;

endmodule

// ===== rtl/core/cmsa_back.sv =====
// Back end: accumulator stores, event count, clearing pass and result register.
// Depends on cmsa_pkg, cmsa_ram and cmsa_math.
module cmsa_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cmsa_pkg::t_job                     i_job,
    input  logic                               i_job_valid,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [cmsa_pkg::CNT_W-1:0]  o_mean_value,
    output logic [cmsa_pkg::CNT_W-1:0]         o_stdev_value,
    output logic [cmsa_pkg::CNT_W-1:0]         o_event_count,
    output logic                               o_has_events,
    output logic                               o_count_overflow
);

    cmsa_pkg::t_bstate r_state, n_state;
    logic [cmsa_pkg::ELEM_AW-1:0] r_clr, n_clr;
    logic [cmsa_pkg::ELEM_AW-1:0] r_idx, n_idx;
    logic [cmsa_pkg::CNT_W-1:0]   r_clips, n_clips;
    logic                         r_ovf, n_ovf;
    logic [cmsa_pkg::SUM_W-1:0]   r_samp, n_samp;
    logic [31:0]                  r_sqt, n_sqt;
    logic                         r_rzero, n_rzero;
    logic                         r_ovalid, n_ovalid;
    logic signed [15:0]           r_omean, n_omean;
    logic [15:0]                  r_ostd, n_ostd;
    logic [15:0]                  r_ocnt, n_ocnt;
    logic                         r_ohas, n_ohas;
    logic                         r_oovf, n_oovf;

    logic                         we;
    logic [cmsa_pkg::ELEM_AW-1:0] waddr;
    logic [cmsa_pkg::SUM_W-1:0]   wsum, rsum;
    logic [cmsa_pkg::SQ_W-1:0]    wsq, rsq;
    logic [15:0]                  mag;
    cmsa_pkg::t_math_req          mreq;
    cmsa_pkg::t_math_rsp          mrsp;

    cmsa_ram #(.WIDTH(cmsa_pkg::SUM_W), .DEPTH(cmsa_pkg::STORE_DEPTH)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wsum),
        .i_raddr (i_job.idx),
        .o_rdata (rsum)
    );

    cmsa_ram #(.WIDTH(cmsa_pkg::SQ_W), .DEPTH(cmsa_pkg::STORE_DEPTH)) u_sq_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wsq),
        .i_raddr (i_job.idx),
        .o_rdata (rsq)
    );

    cmsa_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rsp   (mrsp)
    );

    assign mag = i_job.sample[15] ? (~i_job.sample + 16'd1) : i_job.sample;

    // Next state and store control
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_idx     = r_idx;
        n_clips   = r_clips;
        n_ovf     = r_ovf;
        n_samp    = r_samp;
        n_sqt     = r_sqt;
        n_rzero   = r_rzero;
        n_ovalid  = r_ovalid && !i_ready;
        n_omean   = r_omean;
        n_ostd    = r_ostd;
        n_ocnt    = r_ocnt;
        n_ohas    = r_ohas;
        n_oovf    = r_oovf;
        o_pop     = 1'b0;
        we        = 1'b0;
        waddr     = r_idx;
        wsum      = rsum + r_samp;
        wsq       = rsq + {16'd0, r_sqt};
        mreq.start = 1'b0;
        mreq.sum   = rsum;
        mreq.sq    = rsq;
        mreq.cnt   = r_clips;
        unique case (r_state)
            cmsa_pkg::B_CLEAR: begin
                // Sweep the stores to zero, one entry a cycle
                we    = 1'b1;
                waddr = r_clr;
                wsum  = '0;
                wsq   = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == {cmsa_pkg::ELEM_AW{1'b1}}) begin
                    n_state = cmsa_pkg::B_IDLE;
                end
            end
            cmsa_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    n_idx = i_job.idx;
                    unique case (i_job.op)
                        cmsa_pkg::OP_ADD: begin
                            // Drop adds once the count has saturated
                            if (r_ovf || r_clips == cmsa_pkg::CNT_MAX) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_samp  = {{16{i_job.sample[15]}}, i_job.sample};
                                n_sqt   = mag * mag;
                                if (i_job.last) begin
                                    n_clips = r_clips + 16'd1;
                                end
                                n_state = cmsa_pkg::B_ADD_WB;
                            end
                        end
                        cmsa_pkg::OP_READ: begin
                            if (!i_job.idx_ok || r_clips == '0) begin
                                n_rzero = 1'b1;
                                n_state = cmsa_pkg::B_OUT;
                            end else begin
                                n_rzero = 1'b0;
                                n_state = cmsa_pkg::B_RD_WAIT;
                            end
                        end
                        cmsa_pkg::OP_CLEAR: begin
                            n_clr   = '0;
                            n_clips = '0;
                            n_ovf   = 1'b0;
                            n_state = cmsa_pkg::B_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            cmsa_pkg::B_ADD_WB: begin
                we      = 1'b1;
                n_state = cmsa_pkg::B_IDLE;
            end
            cmsa_pkg::B_RD_WAIT: begin
                mreq.start = 1'b1;
                n_state    = cmsa_pkg::B_MATH;
            end
            cmsa_pkg::B_MATH: begin
                if (mrsp.done) begin
                    n_state = cmsa_pkg::B_OUT;
                end
            end
            cmsa_pkg::B_OUT: begin
                // Load the result register once it is free
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_omean  = r_rzero ? 16'sd0 : mrsp.mean;
                    n_ostd   = r_rzero ? 16'd0 : mrsp.stdev;
                    n_ocnt   = r_clips;
                    n_ohas   = r_clips != '0;
                    n_oovf   = r_ovf;
                    n_state  = cmsa_pkg::B_IDLE;
                end
            end
            default: n_state = cmsa_pkg::B_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cmsa_pkg::B_CLEAR;
            r_clr    <= '0;
            r_clips  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_clips  <= n_clips;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_samp  <= n_samp;
        r_sqt   <= n_sqt;
        r_rzero <= n_rzero;
        r_omean <= n_omean;
        r_ostd  <= n_ostd;
        r_ocnt  <= n_ocnt;
        r_ohas  <= n_ohas;
        r_oovf  <= n_oovf;
    end

    assign o_valid          = r_ovalid;
    assign o_mean_value     = r_omean;
    assign o_stdev_value    = r_ostd;
    assign o_event_count    = r_ocnt;
    assign o_has_events     = r_ohas;
    assign o_count_overflow = r_oovf;

endmodule

// ===== rtl/core/clip_mean_stdev_accumulator_core.sv =====
// Top level: clip size register, front end queue and back end.
// Depends on cmsa_pkg, cmsa_front and cmsa_back.
// Add: store read in B_IDLE, then write back in B_ADD_WB; the next add waits for the write back.
// Read: the shared multiplier, the 64-step divider used twice and the 32-step root run in turn.
// Restart: one store entry cleared per cycle, over all 1024 entries.
// Reset (synchronous, active low) runs the same clearing pass; items queue meanwhile.
module clip_mean_stdev_accumulator_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [cmsa_pkg::EPC_W-1:0]              i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [1:0]                              i_command,
    input  logic [cmsa_pkg::ELEM_AW-1:0]            i_element_index,
    input  logic signed [cmsa_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [cmsa_pkg::CNT_W-1:0]       o_mean_value,
    output logic [cmsa_pkg::CNT_W-1:0]              o_stdev_value,
    output logic [cmsa_pkg::CNT_W-1:0]              o_event_count,
    output logic                                    o_has_events,
    output logic                                    o_count_overflow
);

    logic [cmsa_pkg::EPC_W-1:0] r_epc;
    cmsa_pkg::t_job             job;
    logic                       job_valid;
    logic                       pop;

    // Clip size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epc <= cmsa_pkg::EPC_RESET;
        end else if (i_cfg_we) begin
            r_epc <= i_cfg_data;
        end
    end

    cmsa_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_epc           (r_epc),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_element_index (i_element_index),
        .i_sample        (i_sample),
        .o_job           (job),
        .o_job_valid     (job_valid),
        .i_pop           (pop)
    );

    cmsa_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (job),
        .i_job_valid      (job_valid),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_mean_value     (o_mean_value),
        .o_stdev_value    (o_stdev_value),
        .o_event_count    (o_event_count),
        .o_has_events     (o_has_events),
        .o_count_overflow (o_count_overflow)
    );

endmodule

// ===== verif/cmsa_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the clip mean / standard deviation accumulator.
// Depends on cmsa_pkg; tracks both channels and the clip size register.
module cmsa_result_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [cmsa_pkg::EPC_W-1:0]              i_cfg_data,
    input  logic                                    i_valid,
    input  logic                                    i_in_ready,
    input  logic [1:0]                              i_command,
    input  logic [cmsa_pkg::ELEM_AW-1:0]            i_element_index,
    input  logic signed [cmsa_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                    i_out_valid,
    input  logic                                    i_ready,
    input  logic signed [cmsa_pkg::CNT_W-1:0]       i_mean_value,
    input  logic [cmsa_pkg::CNT_W-1:0]              i_stdev_value,
    input  logic [cmsa_pkg::CNT_W-1:0]              i_event_count,
    input  logic                                    i_has_events,
    input  logic                                    i_count_overflow,
    output int                                      o_fail_count,
    output int                                      o_pending
);

    typedef struct {
        logic signed [cmsa_pkg::CNT_W-1:0] mean;
        logic [cmsa_pkg::CNT_W-1:0]        stdev;
        logic [cmsa_pkg::CNT_W-1:0]        count;
        logic                              has_events;
        logic                              overflow;
    } t_reading;

    logic [cmsa_pkg::SUM_W-1:0] sum_mem [cmsa_pkg::STORE_DEPTH];
    logic [cmsa_pkg::SQ_W-1:0]  sq_mem  [cmsa_pkg::STORE_DEPTH];
    logic [cmsa_pkg::CNT_W-1:0] clips;
    logic                       sat_flag;
    logic [cmsa_pkg::EPC_W-1:0] epc_shadow;
    t_reading                   expected_readings[$];

    assign o_pending = expected_readings.size();

    initial o_fail_count = 0;

    function automatic bit [63:0] floor_root(bit [63:0] x);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Work out the mean and deviation held at one position
    function automatic t_reading predict_reading(logic [cmsa_pkg::ELEM_AW-1:0] idx,
                                                 bit in_range);
        t_reading  rd;
        longint    s;
        longint    m;
        bit [63:0] smag;
        bit [63:0] s2;
        bit [63:0] cs;
        bit [63:0] variance;
        bit [63:0] root;
        rd.mean       = '0;
        rd.stdev      = '0;
        rd.count      = clips;
        rd.has_events = (clips != 0);
        rd.overflow   = sat_flag;
        if (in_range && clips != 0) begin
            s    = longint'($signed(sum_mem[idx]));
            m    = s / longint'(clips);
            if (m > 32767) m = 32767;
            if (m < -32768) m = -32768;
            rd.mean  = m[cmsa_pkg::CNT_W-1:0];
            smag     = (s < 0) ? 64'(-s) : 64'(s);
            s2       = smag * smag;
            cs       = 64'(clips) * 64'(sq_mem[idx]);
            variance = (cs > s2) ? (cs - s2) / (64'(clips) * 64'(clips)) : 64'd0;
            root     = floor_root(variance);
            rd.stdev = (root > 65535) ? 16'hFFFF : root[cmsa_pkg::CNT_W-1:0];
        end
        return rd;
    endfunction

    // Track register writes and input transfers
    always @(posedge i_clk) begin
        bit        in_range;
        longint    s;
        bit [63:0] mag;
        if (!i_rst_n) begin
            foreach (sum_mem[k]) begin
                sum_mem[k] = '0;
                sq_mem[k]  = '0;
            end
            clips      = '0;
            sat_flag   = 1'b0;
            epc_shadow = cmsa_pkg::EPC_RESET;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) epc_shadow = i_cfg_data;
            if (i_valid && i_in_ready) begin
                in_range = (32'(i_element_index) < 32'(epc_shadow));
                case (i_command)
                    cmsa_pkg::CMD_ADD: begin
                        if (in_range) begin
                            if (sat_flag || clips == cmsa_pkg::CNT_MAX) begin
                                sat_flag = 1'b1;
                            end else begin
                                s   = longint'(i_sample);
                                mag = (s < 0) ? 64'(-s) : 64'(s);
                                sum_mem[i_element_index] = sum_mem[i_element_index] + s[31:0];
                                sq_mem[i_element_index]  = sq_mem[i_element_index]
                                                           + cmsa_pkg::SQ_W'(mag * mag);
                                if (32'(i_element_index) == 32'(epc_shadow) - 1)
                                    clips = clips + 1'b1;
                            end
                        end
                    end
                    cmsa_pkg::CMD_READ: expected_readings.push_back(
                        predict_reading(i_element_index, in_range));
                    cmsa_pkg::CMD_RESTART: begin
                        foreach (sum_mem[k]) begin
                            sum_mem[k] = '0;
                            sq_mem[k]  = '0;
                        end
                        clips    = '0;
                        sat_flag = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Compare each result transfer with the oldest reading
    always @(posedge i_clk) begin
        t_reading ex;
        if (i_rst_n && i_out_valid && i_ready) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result, actual mean %0d stdev %0d count %0d",
                         $time, i_mean_value, i_stdev_value, i_event_count);
                o_fail_count <= o_fail_count + 1;
            end else begin
                ex = expected_readings.pop_front();
                if (ex.mean !== i_mean_value || ex.stdev !== i_stdev_value
                        || ex.count !== i_event_count || ex.has_events !== i_has_events
                        || ex.overflow !== i_count_overflow) begin
                    $display("%0t: expected mean %0d stdev %0d count %0d has %0b ovf %0b",
                             $time, ex.mean, ex.stdev, ex.count, ex.has_events, ex.overflow);
                    $display("%0t: actual   mean %0d stdev %0d count %0d has %0b ovf %0b",
                             $time, i_mean_value, i_stdev_value, i_event_count,
                             i_has_events, i_count_overflow);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule

// ===== verif/tb_clip_mean_stdev_accumulator_core.sv =====
`timescale 1ns / 100ps
// Testbench top for clip_mean_stdev_accumulator_core: clock, reset, stimulus, verdict.
// Depends on cmsa_pkg, the core and cmsa_result_checker.
module tb_clip_mean_stdev_accumulator_core;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [cmsa_pkg::EPC_W-1:0]        i_cfg_data;
    logic                              i_valid;
    logic                              o_ready;
    logic [1:0]                        i_command;
    logic [cmsa_pkg::ELEM_AW-1:0]      i_element_index;
    logic signed [15:0]                i_sample;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic signed [15:0]                o_mean_value;
    logic [15:0]                       o_stdev_value;
    logic [15:0]                       o_event_count;
    logic                              o_has_events;
    logic                              o_count_overflow;
    int                                fail_count;
    int                                pending;
    bit                                calm = 1'b0;
    int                                ready_left = 0;
    logic [cmsa_pkg::EPC_W-1:0]        size_now;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    clip_mean_stdev_accumulator_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_command(i_command),
        .i_element_index(i_element_index), .i_sample(i_sample),
        .o_valid(o_valid), .i_ready(i_ready), .o_mean_value(o_mean_value),
        .o_stdev_value(o_stdev_value), .o_event_count(o_event_count),
        .o_has_events(o_has_events), .o_count_overflow(o_count_overflow)
    );

    cmsa_result_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_in_ready(o_ready), .i_command(i_command),
        .i_element_index(i_element_index), .i_sample(i_sample),
        .i_out_valid(o_valid), .i_ready(i_ready), .i_mean_value(o_mean_value),
        .i_stdev_value(o_stdev_value), .i_event_count(o_event_count),
        .i_has_events(o_has_events), .i_count_overflow(o_count_overflow),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Stall the result side in random bursts
    always @(posedge i_clk) begin
        if (calm) begin
            i_ready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            i_ready    <= ~i_ready;
            ready_left <= $urandom_range(0, 16);
        end
    end

    // Present one item, sometimes after a random gap, and hold it until transfer
    task automatic send(cmsa_pkg::t_cmd cmd, logic [cmsa_pkg::ELEM_AW-1:0] idx,
                        logic [15:0] smp);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command       <= cmd;
        i_element_index <= idx;
        i_sample        <= smp;
        i_valid         <= 1'b1;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
    endtask

    // Drain results, let restarts and adds finish, then write the clip size
    task automatic set_clip_size(logic [cmsa_pkg::EPC_W-1:0] value);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        size_now   = value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly in-order clips with random samples, plus reads and noise
    task automatic random_phase(int count);
        int cursor;
        int pick;
        logic [cmsa_pkg::ELEM_AW-1:0] idx;
        cursor = 0;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (size_now != 0) idx = cmsa_pkg::ELEM_AW'($urandom_range(0, size_now - 1));
            else idx = cmsa_pkg::ELEM_AW'($urandom);
            if (pick < 60 && size_now != 0) begin
                send(cmsa_pkg::CMD_ADD, cmsa_pkg::ELEM_AW'(cursor), 16'($urandom));
                cursor = (cursor + 1 >= size_now || cursor + 1 >= cmsa_pkg::STORE_DEPTH)
                         ? 0 : cursor + 1;
            end else if (pick < 85) begin
                send(cmsa_pkg::CMD_READ, idx, 16'($urandom));
            end else if (pick < 91) begin
                send(cmsa_pkg::CMD_ADD, cmsa_pkg::ELEM_AW'($urandom), 16'($urandom));
            end else if (pick < 94) begin
                send(cmsa_pkg::t_cmd'(2'd3), cmsa_pkg::ELEM_AW'($urandom), 16'($urandom));
            end else if (pick < 96) begin
                send(cmsa_pkg::CMD_RESTART, cmsa_pkg::ELEM_AW'($urandom), 16'($urandom));
                cursor = 0;
            end else begin
                send(cmsa_pkg::CMD_READ, cmsa_pkg::ELEM_AW'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_data      <= '0;
        i_valid         <= 1'b0;
        i_command       <= cmsa_pkg::CMD_ADD;
        i_element_index <= '0;
        i_sample        <= '0;
        size_now = cmsa_pkg::EPC_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No events yet, then extremes at the top position
        send(cmsa_pkg::CMD_READ, 10'd0, 16'h0000);
        send(cmsa_pkg::CMD_ADD, 10'd1023, 16'h8000);
        send(cmsa_pkg::CMD_READ, 10'd1023, 16'h0000);

        // Small clips: mean saturation with inconsistent squares
        set_clip_size(11'd2);
        send(cmsa_pkg::CMD_ADD, 10'd0, 16'h7FFF);
        send(cmsa_pkg::CMD_ADD, 10'd0, 16'h7FFF);
        send(cmsa_pkg::CMD_ADD, 10'd1, 16'h8000);
        send(cmsa_pkg::CMD_READ, 10'd0, 16'h0000);
        send(cmsa_pkg::CMD_READ, 10'd1, 16'h0000);
        send(cmsa_pkg::CMD_ADD, 10'd5, 16'h1234);
        send(cmsa_pkg::CMD_READ, 10'd5, 16'h0000);
        send(cmsa_pkg::CMD_READ, 10'd1023, 16'h0000);
        send(cmsa_pkg::t_cmd'(2'd3), 10'd1, 16'hFFFF);
        send(cmsa_pkg::CMD_RESTART, 10'd0, 16'h0000);
        send(cmsa_pkg::CMD_READ, 10'd0, 16'h0000);

        // Zero clip size: nothing is valid
        set_clip_size(11'd0);
        send(cmsa_pkg::CMD_ADD, 10'd0, 16'h0011);
        send(cmsa_pkg::CMD_READ, 10'd0, 16'h0000);

        // Clip size above the store depth: the count never rises
        set_clip_size(11'd2047);
        send(cmsa_pkg::CMD_ADD, 10'd1023, 16'h7FFF);
        send(cmsa_pkg::CMD_READ, 10'd1023, 16'h0000);
        send(cmsa_pkg::CMD_RESTART, 10'd0, 16'h0000);

        // Random phases over several clip sizes; the last runs without stalls
        set_clip_size(11'd3);
        random_phase(150);
        set_clip_size(11'd1);
        random_phase(120);
        set_clip_size(11'd13);
        random_phase(150);
        set_clip_size(11'd1024);
        random_phase(150);
        calm = 1'b1;
        set_clip_size(11'd5);
        random_phase(180);

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Give up on a hang
    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
